### src/focv2d_pkg.sv
// Shared types and constants for the voltage-to-duty pipeline.
// No dependencies; imported by every module of the block.
package focv2d_pkg;

  // One request: q-axis command and electrical angle
  typedef struct packed {
    logic signed [15:0] uq_voltage;
    logic signed [23:0] angle;
  } req_t;

  // One result: three phase duties
  typedef struct packed {
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic [7:0] duty_c;
  } res_t;

  // Angle constants, Q16 radians
  localparam int TWO_PI   = 411775;
  localparam int PI       = 205887;
  localparam int HALF_PI  = 102944;
  // Offset that makes any 24-bit angle positive, a whole number of turns
  localparam int WRAP_OFS = 21 * TWO_PI;
  // floor(2^32 / TWO_PI) for the turn-count estimate
  localparam int RECIP    = 10430;

  localparam int SQRT3    = 113512;
  localparam int CORDIC_K = 39797;
  localparam int STEPS    = 16;

  localparam int ZW = 20;  // angle residue width
  localparam int XW = 20;  // CORDIC vector width
  localparam int UW = 18;  // doubled, clamped command width

  // Travels with each request through the front stages
  typedef struct packed {
    logic                 vld;
    logic                 neg;
    logic signed [UW-1:0] uq2;
  } side_t;

  // Arctangent table, Q16 radians
  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      4'd0:    a = ZW'(51472);
      4'd1:    a = ZW'(30386);
      4'd2:    a = ZW'(16055);
      4'd3:    a = ZW'(8150);
      4'd4:    a = ZW'(4091);
      4'd5:    a = ZW'(2047);
      4'd6:    a = ZW'(1024);
      4'd7:    a = ZW'(512);
      4'd8:    a = ZW'(256);
      4'd9:    a = ZW'(128);
      4'd10:   a = ZW'(64);
      4'd11:   a = ZW'(32);
      4'd12:   a = ZW'(16);
      4'd13:   a = ZW'(8);
      4'd14:   a = ZW'(4);
      default: a = ZW'(2);
    endcase
    return a;
  endfunction

endpackage

### src/focv2d_wrap.sv
// Front end: command clamp and angle wrap into [-pi/2, pi/2] with fold flag.
// Depends on focv2d_pkg. Three register stages.
module focv2d_wrap import focv2d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vld_in,
  input  req_t                 req,
  input  logic [15:0]          sup,
  output logic signed [ZW-1:0] z_out,
  output side_t                side_out
);

  // Stage 1: offset angle, estimate turn count, clamp command
  logic signed [25:0]   us;
  logic [24:0]          u_c;
  logic [38:0]          prod;
  logic signed [UW-1:0] uq2_raw, sup_s, uq2_c;

  assign us      = 26'(req.angle) + 26'(WRAP_OFS);
  assign u_c     = us[24:0];
  assign prod    = 39'(u_c) * 39'(RECIP);
  assign uq2_raw = {req.uq_voltage[15], req.uq_voltage, 1'b0};
  assign sup_s   = {2'b00, sup};

  always_comb begin
    uq2_c = uq2_raw;
    if (uq2_raw > sup_s) uq2_c = sup_s;
    if (uq2_raw < -sup_s) uq2_c = -sup_s;
  end

  logic [24:0] u1;
  logic [5:0]  q1;
  side_t       s1;

  always_ff @(posedge clk) begin
    u1 <= u_c;
    q1 <= prod[37:32];
    s1 <= '{vld: rst ? 1'b0 : vld_in, neg: 1'b0, uq2: uq2_c};
  end

  // Stage 2: remainder, may still be one turn high
  logic [24:0] r_c;
  logic [19:0] r2;
  side_t       s2;

  assign r_c = u1 - 25'(25'(q1) * 25'(TWO_PI));

  always_ff @(posedge clk) begin
    r2 <= r_c[19:0];
    s2 <= '{vld: rst ? 1'b0 : s1.vld, neg: s1.neg, uq2: s1.uq2};
  end

  // Stage 3: final correction, move to [-pi, pi), fold into +/- pi/2
  logic [19:0]        r_m;
  logic signed [20:0] rs, rf;
  logic               neg_c;

  always_comb begin
    r_m = (r2 >= 20'(TWO_PI)) ? r2 - 20'(TWO_PI) : r2;
    rs  = 21'(r_m);
    if (rs >= 21'(PI)) rs = rs - 21'(TWO_PI);
    rf    = rs;
    neg_c = 1'b0;
    if (rs > 21'(HALF_PI)) begin
      rf    = rs - 21'(PI);
      neg_c = 1'b1;
    end else if (rs < -21'(HALF_PI)) begin
      rf    = rs + 21'(PI);
      neg_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    z_out    <= rf[ZW-1:0];
    side_out <= '{vld: rst ? 1'b0 : s2.vld, neg: neg_c, uq2: s2.uq2};
  end

endmodule

### src/focv2d_cordic.sv
// Rotation CORDIC, one iteration per register stage, gives sin and cos.
// Depends on focv2d_pkg for the arctangent table and widths.
module focv2d_cordic import focv2d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [ZW-1:0] z_in,
  input  side_t                side_in,
  output logic signed [XW-1:0] sin_out,
  output logic signed [XW-1:0] cos_out,
  output side_t                side_out
);

  logic signed [XW-1:0] xp [0:STEPS];
  logic signed [XW-1:0] yp [0:STEPS];
  logic signed [ZW-1:0] zp [0:STEPS];
  side_t                sp [0:STEPS];

  assign xp[0] = XW'(CORDIC_K);
  assign yp[0] = '0;
  assign zp[0] = z_in;
  assign sp[0] = side_in;

  // One micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_it
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = yp[i] >>> i;
    assign dy = xp[i] >>> i;
    assign at = atan_lut(4'(i));

    always_ff @(posedge clk) begin
      if (zp[i] >= 0) begin
        xp[i+1] <= xp[i] - dx;
        yp[i+1] <= yp[i] + dy;
        zp[i+1] <= zp[i] - at;
      end else begin
        xp[i+1] <= xp[i] + dx;
        yp[i+1] <= yp[i] - dy;
        zp[i+1] <= zp[i] + at;
      end
      sp[i+1] <= '{vld: rst ? 1'b0 : sp[i].vld, neg: sp[i].neg, uq2: sp[i].uq2};
    end
  end

  // Undo the fold
  assign sin_out  = sp[STEPS].neg ? -yp[STEPS] : yp[STEPS];
  assign cos_out  = sp[STEPS].neg ? -xp[STEPS] : xp[STEPS];
  assign side_out = sp[STEPS];

endmodule

### src/focv2d_duty.sv
// Back end: inverse Park/Clarke, phase clamp, scale and pipelined division.
// Depends on focv2d_pkg. 4 + QW register stages.
module focv2d_duty import focv2d_pkg::*; #(
  parameter int DUTY_MAX = 255,
  parameter int QW       = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [XW-1:0] sin_in,
  input  logic signed [XW-1:0] cos_in,
  input  side_t                side_in,
  input  logic [15:0]          sup,
  output logic                 done,
  output res_t                 result
);

  localparam int NW = 32 + QW;

  // Stage A: command times sin and cos
  logic signed [37:0] pa, ma;
  logic               va;

  always_ff @(posedge clk) begin
    pa <= 38'(side_in.uq2) * 38'(sin_in);
    ma <= 38'(side_in.uq2) * 38'(cos_in);
    va <= rst ? 1'b0 : side_in.vld;
  end

  // Stage B: beta scaling by sqrt(3), alpha term aligned
  logic signed [59:0] qb, pb;
  logic               vb;

  always_ff @(posedge clk) begin
    qb <= 60'(56'(ma) * 56'(SQRT3));
    pb <= 60'(pa) <<< 16;
    vb <= rst ? 1'b0 : va;
  end

  // Stage C: phase voltages, clamp to [0, supply], drop 17 bits
  function automatic logic [31:0] to_v(input logic signed [59:0] ph,
                                       input logic signed [59:0] top);
    logic signed [59:0] t;
    t = (ph < 0) ? '0 : ph;
    if (t > top) t = top;
    return t[48:17];
  endfunction

  logic signed [59:0] half2, ph_a, ph_b, ph_c;
  logic [31:0]        vc [0:2];
  logic               vcv;

  assign half2 = 60'({sup, 33'b0});
  assign ph_a  = half2 - (pb <<< 1);
  assign ph_b  = half2 + qb + pb;
  assign ph_c  = half2 + pb - qb;

  always_ff @(posedge clk) begin
    vc[0] <= to_v(ph_a, half2);
    vc[1] <= to_v(ph_b, half2);
    vc[2] <= to_v(ph_c, half2);
    vcv   <= rst ? 1'b0 : vb;
  end

  // Stage D: numerators v * DUTY_MAX
  logic [NW-1:0] rem [0:QW][0:2];
  logic [QW-1:0] quo [0:QW][0:2];
  logic          vq  [0:QW];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      rem[0][l] <= NW'(vc[l]) * NW'(DUTY_MAX);
      quo[0][l] <= '0;
    end
    vq[0] <= rst ? 1'b0 : vcv;
  end

  // Restoring division by supply * 2^16, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [NW-1:0] dsh;
    assign dsh = NW'({sup, 16'b0}) << (QW - 1 - j);

    always_ff @(posedge clk) begin
      for (int l = 0; l < 3; l++) begin
        if (rem[j][l] >= dsh) begin
          rem[j+1][l] <= rem[j][l] - dsh;
          quo[j+1][l] <= quo[j][l] | (QW'(1) << (QW - 1 - j));
        end else begin
          rem[j+1][l] <= rem[j][l];
          quo[j+1][l] <= quo[j][l];
        end
      end
      vq[j+1] <= rst ? 1'b0 : vq[j];
    end
  end

  // Duties keep the low 8 bits
  assign done          = vq[QW];
  assign result.duty_a = 8'({8'b0, quo[QW][0]});
  assign result.duty_b = 8'({8'b0, quo[QW][1]});
  assign result.duty_c = 8'({8'b0, quo[QW][2]});

endmodule

### src/foc_voltage_to_pwm_duty_core.sv
// Voltage command to three-phase PWM duty, fully pipelined.
// Requests pass the wrap stages, the 16-stage CORDIC and the duty stages with
// the one-bit-per-stage divider; throughput one request per cycle, busy stays
// low. Results show for one cycle on done.
// Synchronous reset clears all valid bits and loads supply to 12 V (3072).
// Depends on focv2d_pkg, focv2d_wrap, focv2d_cordic, focv2d_duty.
module foc_voltage_to_pwm_duty_core import focv2d_pkg::*; #(
  parameter int DUTY_MAX = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output res_t        result,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int QW  = $clog2(DUTY_MAX + 1);
  localparam int LAT = 3 + STEPS + 4 + QW;

  // Supply register; zero behaves as one
  logic [15:0] supply, sup_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply <= 16'd3072;
    end else if (cfg_we) begin
      supply <= cfg_wdata;
    end
  end

  assign sup_eff = (supply == '0) ? 16'd1 : supply;
  assign busy    = 1'b0;

  logic signed [ZW-1:0] z_w;
  side_t                side_w, side_c;
  logic signed [XW-1:0] s_c, c_c;

  focv2d_wrap u_wrap (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (start && !busy),
    .req      (req),
    .sup      (sup_eff),
    .z_out    (z_w),
    .side_out (side_w)
  );

  focv2d_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .z_in     (z_w),
    .side_in  (side_w),
    .sin_out  (s_c),
    .cos_out  (c_c),
    .side_out (side_c)
  );

  focv2d_duty #(.DUTY_MAX(DUTY_MAX), .QW(QW)) u_duty (
    .clk     (clk),
    .rst     (rst),
    .sin_in  (s_c),
    .cos_in  (c_c),
    .side_in (side_c),
    .sup     (sup_eff),
    .done    (done),
    .result  (result)
  );

endmodule

### src/focv2d_checker.sv
// Port-level checks of the voltage-to-duty core, attached by bind.
// Depends on focv2d_pkg and foc_voltage_to_pwm_duty_core.
module focv2d_checker import focv2d_pkg::*; #(
  parameter int LAT      = 31,
  parameter int DUTY_MAX = 255
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t result
);

  // The pipeline never pushes back
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // Every request yields a result after the fixed latency
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing");

  // No result without a request
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("spurious result");

  // Duties stay within full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (DUTY_MAX > 255) ||
             (result.duty_a <= 8'(DUTY_MAX) && result.duty_b <= 8'(DUTY_MAX) &&
              result.duty_c <= 8'(DUTY_MAX)))
    else $error("duty out of range");

endmodule

bind foc_voltage_to_pwm_duty_core focv2d_checker #(
  .LAT(LAT), .DUTY_MAX(DUTY_MAX)
) u_chk (.*);
